@@ rtl/core/weighted_pick_excluding_id_core_assert.svh @@
// Assertion macros used by the checker of the weighted pick core.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef WEIGHTED_PICK_EXCLUDING_ID_CORE_ASSERT_SVH
`define WEIGHTED_PICK_EXCLUDING_ID_CORE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define WPEI_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("weighted pick core: invariant violated");

// When the antecedent holds, the consequent holds at the next clock edge.
`define WPEI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("weighted pick core: next-cycle property violated");

`endif

@@ rtl/core/wpei_pkg.sv @@
`timescale 1ns / 1ps

package wpei_pkg;

	localparam int ID_W      = 32;
	localparam int WEIGHT_W  = 16;
	localparam int RND_W     = 32;
	localparam int REQ_W     = 2;
	localparam int MOD_CNT_W = $clog2(RND_W);
	localparam int ENTRY_W   = ID_W + WEIGHT_W;

	// Request codes carried on the input tuser.
	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_PICK   = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SUM  = 5'b00010,
		ST_MOD  = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

@@ rtl/core/wpei_ram.sv @@
`timescale 1ns / 1ps

// Single-port-write, single-port-read RAM with a registered read.
module wpei_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/weighted_pick_excluding_id_core.sv @@
`timescale 1ns / 1ps

// Weighted random pick over a table of (id, weight) pairs that skips one id.
// Each input item carries a request code on s_tuser: clear empties the table,
// append stores one pair at the next free slot (or reports table_full when all
// MAX_ENTRIES slots are taken), pick sums the weights of every entry whose id
// differs from exclude_id, reduces random_word to a draw of 1 + (random_word
// mod sum), and returns the first such entry in table order whose running sum
// reaches the draw. When that sum is zero the pick returns exclude_id with
// fell_back set. Code three is a no-operation whose result is all zeros. Every
// item yields exactly one result item. The table lives in one synchronous RAM
// with a registered read, so a pick walks it twice, one entry per cycle, with a
// bit-serial restoring modulo of 32 steps in between. A pick runs the summing
// walk, then the modulo, then the scan, which stops at the chosen entry, and
// then loads the output register. A pick whose sum is zero skips the modulo
// and the scan. Clear, append and no-operation go from acceptance straight to
// the done state. A result waits in the done state while the output register
// still holds a previous result that m_tready has not taken. The block accepts
// one item at a time; a new item can be taken in the cycle after the previous
// result has moved into the output register, even if that result is still
// waiting for m_tready. No clearing pass is needed after reset, since only
// slots below the entry count are ever read.
module weighted_pick_excluding_id_core #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	// Input items.
	input  logic          s_tvalid,
	output logic          s_tready,
	// From bit 0: entry_id[31:0], entry_weight[47:32], exclude_id[79:48],
	// random_word[111:80].
	input  logic [111:0]  s_tdata,
	// From bit 0: req_type[1:0].
	input  logic [1:0]    s_tuser,
	// Result items.
	output logic          m_tvalid,
	input  logic          m_tready,
	// From bit 0: chosen_id[31:0].
	output logic [31:0]   m_tdata,
	// From bit 0: fell_back[0], table_full[1].
	output logic [1:0]    m_tuser
);

	// Entry count must hold MAX_ENTRIES itself; the RAM index only needs the depth.
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	// A weight sum never exceeds MAX_ENTRIES * 65535, which fits this width.
	localparam int SUM_W = wpei_pkg::WEIGHT_W + CNT_W;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);

	// Unpacked input fields.
	logic [wpei_pkg::ID_W-1:0]     in_id;
	logic [wpei_pkg::WEIGHT_W-1:0] in_weight;
	logic [wpei_pkg::ID_W-1:0]     in_skip;
	logic [wpei_pkg::RND_W-1:0]    in_rnd;
	wpei_pkg::req_t                in_req;

	assign in_id     = s_tdata[31:0];
	assign in_weight = s_tdata[47:32];
	assign in_skip   = s_tdata[79:48];
	assign in_rnd    = s_tdata[111:80];
	assign in_req    = wpei_pkg::req_t'(s_tuser);

	wpei_pkg::state_t st_q;

	logic [CNT_W-1:0]              cnt_q;
	logic [CNT_W-1:0]              rd_q;
	logic                          vld_s1;
	logic [wpei_pkg::ID_W-1:0]     skip_q;
	logic [wpei_pkg::RND_W-1:0]    rnd_q;
	logic [SUM_W-1:0]              total_q;
	logic [SUM_W-1:0]              rem_q;
	logic [wpei_pkg::MOD_CNT_W-1:0] bit_q;
	logic [SUM_W-1:0]              draw_q;
	logic [SUM_W-1:0]              run_q;

	// Pending result, moved into the output register from the done state.
	logic [wpei_pkg::ID_W-1:0]     res_id_q;
	logic                          res_fb_q;
	logic                          res_full_q;

	logic                          m_tvalid_q;
	logic [31:0]                   m_tdata_q;
	logic [1:0]                    m_tuser_q;

	// RAM interface. Each entry holds the weight above the id.
	logic                          ram_we;
	logic [IDX_W-1:0]              ram_waddr;
	logic [wpei_pkg::ENTRY_W-1:0]  ram_wdata;
	logic                          ram_re;
	logic [IDX_W-1:0]              ram_raddr;
	logic [wpei_pkg::ENTRY_W-1:0]  ram_rdata;

	logic                          accept;
	logic                          table_full;
	logic                          walking;
	logic                          walk_done;
	logic [wpei_pkg::ID_W-1:0]     rd_id;
	logic [SUM_W-1:0]              rd_weight;
	logic                          rd_counts;
	logic [SUM_W-1:0]              run_next;
	logic [SUM_W:0]                rem_shift;
	logic [SUM_W:0]                rem_diff;
	logic [SUM_W-1:0]              rem_next;
	logic                          out_free;

	assign s_tready   = (st_q == wpei_pkg::ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign table_full = (cnt_q == CNT_FULL);
	assign out_free   = !m_tvalid_q || m_tready;

	// Appends write in the cycle they are accepted; reads only happen during the
	// two table walks of a pick, so a read and a write never meet on one entry.
	assign ram_we    = accept && (in_req == wpei_pkg::REQ_APPEND) && !table_full;
	assign ram_waddr = cnt_q[IDX_W-1:0];
	assign ram_wdata = {in_weight, in_id};

	// Both walks issue one read per cycle over the live slots; vld_s1 marks
	// the cycle in which the read data arrives.
	assign walking   = (st_q == wpei_pkg::ST_SUM) || (st_q == wpei_pkg::ST_SCAN);
	assign ram_re    = walking && (rd_q < cnt_q);
	assign ram_raddr = rd_q[IDX_W-1:0];
	assign walk_done = !ram_re && !vld_s1;

	assign rd_id     = ram_rdata[wpei_pkg::ID_W-1:0];
	assign rd_weight = {{CNT_W{1'b0}}, ram_rdata[wpei_pkg::ENTRY_W-1:wpei_pkg::ID_W]};
	assign rd_counts = vld_s1 && (rd_id != skip_q);
	assign run_next  = run_q + rd_weight;

	// One step of the restoring modulo: bring in the next random bit, MSB first.
	// The remainder stays below the total, so the shifted value stays below
	// twice the total and one conditional subtract restores it.
	assign rem_shift = {rem_q, rnd_q[wpei_pkg::RND_W-1]};
	assign rem_diff  = rem_shift - {1'b0, total_q};
	assign rem_next  = (rem_shift >= {1'b0, total_q}) ? rem_diff[SUM_W-1:0]
	                                                   : rem_shift[SUM_W-1:0];

	wpei_ram #(
		.WIDTH (wpei_pkg::ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control: state, entry count, walk pointer, read-valid flag, modulo bit counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= wpei_pkg::ST_IDLE;
			cnt_q      <= '0;
			rd_q       <= '0;
			vld_s1     <= 1'b0;
			bit_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			vld_s1 <= ram_re;
			if (ram_re) begin
				rd_q <= rd_q + 1'b1;
			end

			// The output register loads from the done state and empties on a take.
			if ((st_q == wpei_pkg::ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (st_q)
				wpei_pkg::ST_IDLE: begin
					if (accept) begin
						rd_q <= '0;
						case (in_req)
							wpei_pkg::REQ_CLEAR: begin
								cnt_q <= '0;
								st_q  <= wpei_pkg::ST_DONE;
							end
							wpei_pkg::REQ_APPEND: begin
								if (!table_full) begin
									cnt_q <= cnt_q + 1'b1;
								end
								st_q <= wpei_pkg::ST_DONE;
							end
							wpei_pkg::REQ_PICK: begin
								st_q <= wpei_pkg::ST_SUM;
							end
							default: begin
								st_q <= wpei_pkg::ST_DONE;
							end
						endcase
					end
				end
				wpei_pkg::ST_SUM: begin
					if (walk_done) begin
						bit_q <= '0;
						st_q  <= (total_q == '0) ? wpei_pkg::ST_DONE : wpei_pkg::ST_MOD;
					end
				end
				wpei_pkg::ST_MOD: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == wpei_pkg::MOD_CNT_W'(wpei_pkg::RND_W - 1)) begin
						rd_q <= '0;
						st_q <= wpei_pkg::ST_SCAN;
					end
				end
				wpei_pkg::ST_SCAN: begin
					if ((rd_counts && (draw_q <= run_next)) || walk_done) begin
						st_q <= wpei_pkg::ST_DONE;
					end
				end
				wpei_pkg::ST_DONE: begin
					if (out_free) begin
						st_q <= wpei_pkg::ST_IDLE;
					end
				end
				default: begin
					st_q <= wpei_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: pick operands, sums, modulo, the pending result and the output data.
	always_ff @(posedge clk) begin
		case (st_q)
			wpei_pkg::ST_IDLE: begin
				if (accept) begin
					skip_q     <= in_skip;
					rnd_q      <= in_rnd;
					total_q    <= '0;
					rem_q      <= '0;
					// A pick starts from the fallback result unless the scan finds
					// an entry; only a dropped append reports table_full.
					res_id_q   <= (in_req == wpei_pkg::REQ_PICK) ? in_skip : '0;
					res_fb_q   <= (in_req == wpei_pkg::REQ_PICK);
					res_full_q <= (in_req == wpei_pkg::REQ_APPEND) && table_full;
				end
			end
			wpei_pkg::ST_SUM: begin
				if (rd_counts) begin
					total_q <= total_q + rd_weight;
				end
			end
			wpei_pkg::ST_MOD: begin
				rem_q <= rem_next;
				rnd_q <= {rnd_q[wpei_pkg::RND_W-2:0], 1'b0};
				run_q <= '0;
				if (bit_q == wpei_pkg::MOD_CNT_W'(wpei_pkg::RND_W - 1)) begin
					draw_q <= rem_next + 1'b1;
				end
			end
			wpei_pkg::ST_SCAN: begin
				if (rd_counts) begin
					run_q <= run_next;
					if (draw_q <= run_next) begin
						res_id_q <= rd_id;
						res_fb_q <= 1'b0;
					end
				end
			end
			wpei_pkg::ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= res_id_q;
					m_tuser_q <= {res_full_q, res_fb_q};
				end
			end
			default: begin
				run_q <= run_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ rtl/core/wpei_checker.sv @@
`timescale 1ns / 1ps

`include "weighted_pick_excluding_id_core_assert.svh"

// Port-level checks of the weighted pick core.
module wpei_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A stalled result item keeps its contents.
	`WPEI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Only one item is worked on at a time: acceptance closes the input.
	`WPEI_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

	// A dropped append never also reports a fallback.
	`WPEI_ASSERT_ALWAYS(a_flags_excl, !(m_tvalid && m_tuser[0] && m_tuser[1]))

	// A dropped append returns a zero id.
	`WPEI_ASSERT_ALWAYS(a_full_zero_id, !(m_tvalid && m_tuser[1]) || (m_tdata == 32'd0))

endmodule

bind weighted_pick_excluding_id_core wpei_checker u_wpei_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import wpei_pkg::*;

	localparam int TABLE_DEPTH = 16;

	// One expected result item, with the fields that the block presents on m_tdata and m_tuser.
	typedef struct packed {
		logic [ID_W-1:0] chosen_id;
		logic            fell_back;
		logic            table_full;
	} pick_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;
	logic [1:0]   m_tuser;

	weighted_pick_excluding_id_core #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// Our own copy of the table, updated as each item is accepted.
	logic [ID_W-1:0]     table_ids [TABLE_DEPTH];
	logic [WEIGHT_W-1:0] table_weights [TABLE_DEPTH];
	int unsigned         table_count;

	pick_result_t expected_results[$];
	pick_result_t oldest_result;
	int unsigned  err_count;
	int unsigned  items_sent;
	int unsigned  send_idle_pct;
	int unsigned  recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs; far beyond the slowest legal run.
	initial begin
		#10ms;
		$display("tb NOT OK");
		$finish;
	end

	// Works out the result of one request and applies its effect on the table.
	function automatic pick_result_t predict_request(input req_t req, input logic [31:0] id,
			input logic [15:0] weight, input logic [31:0] skip_id, input logic [31:0] rnd);
		pick_result_t res;
		logic [31:0]  total;
		logic [31:0]  draw;
		logic [31:0]  running;
		bit           found;
		res = '0;
		case (req)
			REQ_CLEAR: begin
				table_count = 0;
			end
			REQ_APPEND: begin
				if (table_count >= TABLE_DEPTH) begin
					res.table_full = 1'b1;
				end else begin
					table_ids[table_count] = id;
					table_weights[table_count] = weight;
					table_count++;
				end
			end
			REQ_PICK: begin
				total = '0;
				for (int i = 0; i < table_count; i++) begin
					if (table_ids[i] != skip_id)
						total += table_weights[i];
				end
				res.chosen_id = skip_id;
				res.fell_back = 1'b1;
				if (total != 0) begin
					draw = 32'd1 + (rnd % total);
					running = '0;
					found = 1'b0;
					for (int i = 0; i < table_count; i++) begin
						if (!found && table_ids[i] != skip_id) begin
							running += table_weights[i];
							if (draw <= running) begin
								res.chosen_id = table_ids[i];
								res.fell_back = 1'b0;
								found = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_count++;
		if (err_count <= 50)
			$display("mismatch on %s: got %0h, expected %0h", what, got, want);
	endtask

	// Offers one item, with a random idle gap first, and records its expected
	// result at the edge where it is accepted. Valid stays high afterwards so
	// back-to-back items never lower and raise it in the same step.
	task automatic send_item(input req_t req, input logic [31:0] id, input logic [15:0] weight,
			input logic [31:0] skip_id, input logic [31:0] rnd);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {rnd, skip_id, weight, id};
		do
			@(posedge clk);
		while (!s_tready);
		expected_results.insert(expected_results.size(),
			predict_request(req, id, weight, skip_id, rnd));
		if (req != REQ_NOP)
			items_sent++;
	endtask

	// Stops offering items and waits for every outstanding result.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	// Ids drawn partly from a handful of values so that exclusions hit.
	function automatic logic [31:0] random_id_value();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] random_weight();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return $urandom_range(1, 15);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// Empty table, a table whose only weight is excluded, a zero weight sum,
	// and a no-operation with every field bit set.
	task automatic test_fallback_cases();
		send_item(REQ_CLEAR, '1, '1, '1, '1);
		send_item(REQ_PICK, '0, '0, $urandom, $urandom);
		send_item(REQ_APPEND, 32'hA5A5_5A5A, 16'hFFFF, '0, '0);
		send_item(REQ_PICK, '0, '0, 32'hA5A5_5A5A, $urandom);
		send_item(REQ_APPEND, 32'h0000_0001, 16'h0000, '0, '0);
		send_item(REQ_PICK, '0, '0, 32'hA5A5_5A5A, $urandom);
		send_item(REQ_NOP, '1, '1, '1, '1);
		drain_results();
	endtask

	// Fills all sixteen slots with extreme ids and weights, overflows once,
	// then picks with extreme random words and exclusions.
	task automatic test_full_table();
		send_item(REQ_CLEAR, '0, '0, '0, '0);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			case (i % 4)
				0: send_item(REQ_APPEND, 32'h0000_0000, 16'hFFFF, '0, '0);
				1: send_item(REQ_APPEND, 32'hFFFF_FFFF, 16'h0000, '0, '0);
				2: send_item(REQ_APPEND, 32'h0000_0005, 16'h0001, '0, '0);
				default: send_item(REQ_APPEND, $urandom, $urandom_range(0, 65535), '0, '0);
			endcase
		end
		send_item(REQ_APPEND, '1, '1, '0, '0);
		send_item(REQ_PICK, '0, '0, 32'h0000_0005, 32'h0000_0000);
		send_item(REQ_PICK, '0, '0, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(REQ_PICK, '0, '0, 32'hFFFF_FFFF, $urandom);
		drain_results();
	endtask

	// Mostly well-formed runs: clear, a batch of appends (sometimes filling
	// or overflowing the table), then picks. The rest is loose noise.
	task automatic test_random_sequences(input int unsigned target,
			input int unsigned send_pct, input int unsigned recv_pct);
		int unsigned first_count;
		int unsigned num_appends;
		int unsigned num_picks;
		logic [31:0] id_pool [3];
		logic [31:0] skip_id;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		first_count = items_sent;
		while (items_sent - first_count < target) begin
			if ($urandom_range(99) < 80) begin
				foreach (id_pool[i])
					id_pool[i] = random_id_value();
				send_item(REQ_CLEAR, $urandom, $urandom_range(0, 65535), $urandom, $urandom);
				case ($urandom_range(9))
					0: num_appends = TABLE_DEPTH;
					1: num_appends = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 3);
					default: num_appends = $urandom_range(0, 8);
				endcase
				repeat (num_appends) begin
					if ($urandom_range(3) != 0)
						send_item(REQ_APPEND, id_pool[$urandom_range(2)], random_weight(),
							$urandom, $urandom);
					else
						send_item(REQ_APPEND, $urandom, random_weight(), $urandom, $urandom);
				end
				num_picks = $urandom_range(1, 5);
				repeat (num_picks) begin
					if ($urandom_range(9) < 7)
						skip_id = id_pool[$urandom_range(2)];
					else
						skip_id = random_id_value();
					send_item(REQ_PICK, $urandom, $urandom_range(0, 65535), skip_id, $urandom);
				end
			end else begin
				send_item(req_t'($urandom_range(0, 3)), random_id_value(),
					$urandom_range(0, 65535), random_id_value(), $urandom);
			end
		end
		drain_results();
	endtask

	// Result checker and receiver stalls.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", m_tdata, '0);
			end else begin
				oldest_result = expected_results.pop_front();
				if (m_tdata !== oldest_result.chosen_id)
					report_mismatch("chosen_id", m_tdata, oldest_result.chosen_id);
				if (m_tuser[0] !== oldest_result.fell_back)
					report_mismatch("fell_back", m_tuser[0], oldest_result.fell_back);
				if (m_tuser[1] !== oldest_result.table_full)
					report_mismatch("table_full", m_tuser[1], oldest_result.table_full);
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		err_count      = 0;
		items_sent     = 0;
		table_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= REQ_NOP;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fallback_cases();
		test_full_table();
		test_random_sequences(380, 0, 0);
		test_random_sequences(380, 82, 0);
		test_random_sequences(380, 0, 82);
		test_random_sequences(380, 29, 29);

		// Let any stray result show up before the verdict.
		repeat (100) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
